// ----- src/rlbs_pkg.sv -----
// Shared types and constants for the region lookup binary search core.
package rlbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int POS_W       = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } rlbs_state_t;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
  } region_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    region_t           wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } table_req_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] doc_number;
    logic [POS_W-1:0]   hit_start;
    logic [POS_W-1:0]   hit_size;
  } result_t;

endpackage

// ----- src/region_lookup_binary_search_core.sv -----
// Top level of the region lookup binary search core.
//
// Input channel (in_valid / in_stall) carries one item: operation selects a
// table write (entry_index, entry_start, entry_end) or a search (target).
// A write item is written to the table as it is accepted and gives no
// result. A search item runs a binary search over the first region_count
// table entries (clamped to the table depth); each probe is a registered
// table read (ST_PROBE) followed by a compare (ST_CMP), with at most 11
// probes for a full 1024-entry table, and the result waits in ST_DONE
// until the output register takes it. One item is in work at a time;
// in_stall stays high until the result leaves the sequencer.
// Output channel (out_valid / out_stall) holds the result in a register:
// found, doc_number, hit_start, hit_size. While out_stall is high the result
// holds, a new item is still accepted, and its result waits in the
// sequencer until the output register frees up.
// The user writes region_count through cfg_wr_en / cfg_wr_data only while
// idle; the block does not enforce it. Reset (rst, synchronous) clears the
// sequencer, out_valid and region_count; table is undefined until written.
module region_lookup_binary_search_core
  import rlbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [ADDR_W-1:0]  entry_index,
  input  logic [POS_W-1:0]   entry_start,
  input  logic [POS_W-1:0]   entry_end,
  input  logic [POS_W-1:0]   target,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               found,
  output logic [COUNT_W-1:0] doc_number,
  output logic [POS_W-1:0]   hit_start,
  output logic [POS_W-1:0]   hit_size
);

  logic [COUNT_W-1:0] region_count;
  table_req_t         table_req;
  region_t            rd_data;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (cfg_wr_en) begin
      region_count <= cfg_wr_data;
    end
  end

  rlbs_table u_table (
    .clk     (clk),
    .req     (table_req),
    .rd_data (rd_data)
  );

  rlbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .entry_index  (entry_index),
    .entry_start  (entry_start),
    .entry_end    (entry_end),
    .target       (target),
    .region_count (region_count),
    .table_req    (table_req),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  // Load the output register when it is empty or being taken.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      found      <= res.found;
      doc_number <= res.doc_number;
      hit_start  <= res.hit_start;
      hit_size   <= res.hit_size;
    end
  end

endmodule

// ----- src/rlbs_table.sv -----
// Region table memory: one write port, one registered read port.
module rlbs_table
  import rlbs_pkg::*;
(
  input  logic       clk,
  input  table_req_t req,
  output region_t    rd_data
);

  region_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ----- src/rlbs_ctrl.sv -----
// Search sequencer: accepts items, steps the binary search, forms the result.
module rlbs_ctrl
  import rlbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [ADDR_W-1:0]  entry_index,
  input  logic [POS_W-1:0]   entry_start,
  input  logic [POS_W-1:0]   entry_end,
  input  logic [POS_W-1:0]   target,
  input  logic [COUNT_W-1:0] region_count,
  output table_req_t         table_req,
  input  region_t            rd_data,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);

  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

  rlbs_state_t state, state_next;

  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] hi;
  logic [ADDR_W-1:0]  probe;
  logic [POS_W-1:0]   tgt;

  logic               accept;
  logic [COUNT_W-1:0] n_clamped;
  logic [COUNT_W:0]   mid_sum;
  logic [ADDR_W-1:0]  probe_calc;
  logic               go_right;
  logic               go_left;
  logic               hit_now;
  logic [COUNT_W-1:0] probe_inc;
  logic [COUNT_W-1:0] lo_next;
  logic [COUNT_W-1:0] hi_next;
  logic               finish;
  result_t            cmp_res;

  assign accept     = in_valid && !in_stall;
  assign n_clamped  = (region_count > DEPTH_C) ? DEPTH_C : region_count;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign probe_calc = mid_sum[ADDR_W:1];

  // Compare the probed region against the target.
  assign go_right  = rd_data.end_pos <= tgt;
  assign go_left   = !go_right && (tgt < rd_data.start_pos);
  assign hit_now   = !go_right && !go_left;
  assign probe_inc = {1'b0, probe} + COUNT_W'(1);
  assign lo_next   = go_right ? probe_inc : lo;
  assign hi_next   = go_left ? {1'b0, probe} : hi;
  assign finish    = hit_now || (lo_next >= hi_next);

  always_comb begin
    cmp_res.found = hit_now;
    if (hit_now) begin
      cmp_res.doc_number = {1'b0, probe};
      cmp_res.hit_start  = rd_data.start_pos;
      cmp_res.hit_size   = rd_data.end_pos - rd_data.start_pos;
    end else begin
      cmp_res.doc_number = (tgt < rd_data.start_pos) ? '0 : probe_inc;
      cmp_res.hit_start  = '0;
      cmp_res.hit_size   = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && operation == OP_SEARCH) begin
          state_next = (n_clamped == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: state_next = ST_CMP;
      ST_CMP:   state_next = finish ? ST_DONE : ST_PROBE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall          = 1'b1;
    res_valid         = 1'b0;
    table_req.wr_en   = 1'b0;
    table_req.wr_addr = entry_index;
    table_req.wr_data = '{start_pos: entry_start, end_pos: entry_end};
    table_req.rd_en   = 1'b0;
    table_req.rd_addr = probe_calc;
    unique case (state)
      ST_IDLE: begin
        in_stall        = 1'b0;
        table_req.wr_en = in_valid && operation == OP_WRITE;
      end
      ST_PROBE: table_req.rd_en = 1'b1;
      ST_CMP:   ;
      ST_DONE:  res_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept && operation == OP_SEARCH) begin
          lo  <= '0;
          hi  <= n_clamped;
          tgt <= target;
          // Empty table: miss with document number zero.
          res <= '0;
        end
      end
      ST_PROBE: probe <= probe_calc;
      ST_CMP: begin
        lo <= lo_next;
        hi <= hi_next;
        if (finish) begin
          res <= cmp_res;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

endmodule

// ----- tb/tb_region_lookup_binary_search_core.sv -----
// Self-checking testbench for the region lookup binary search core.
`timescale 1ns / 100ps

module tb_region_lookup_binary_search_core;
  import rlbs_pkg::*;

  localparam int DRAIN_CYCLES = 30;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = OP_WRITE;
  logic [ADDR_W-1:0]  entry_index = '0;
  logic [POS_W-1:0]   entry_start = '0;
  logic [POS_W-1:0]   entry_end = '0;
  logic [POS_W-1:0]   target = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found;
  logic [COUNT_W-1:0] doc_number;
  logic [POS_W-1:0]   hit_start;
  logic [POS_W-1:0]   hit_size;

  region_lookup_binary_search_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .entry_index (entry_index),
    .entry_start (entry_start),
    .entry_end   (entry_end),
    .target      (target),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .doc_number  (doc_number),
    .hit_start   (hit_start),
    .hit_size    (hit_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the region table and count register
  logic [POS_W-1:0]   shadow_start [TABLE_DEPTH];
  logic [POS_W-1:0]   shadow_end   [TABLE_DEPTH];
  bit                 written      [TABLE_DEPTH];
  logic [COUNT_W-1:0] shadow_count = '0;

  result_t pending_results [$];

  int errors          = 0;
  int items_sent      = 0;
  int searches_sent   = 0;
  int results_checked = 0;
  int settings_used   = 0;

  bit valid_q    = 1'b0;
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  function automatic result_t lookup_region(input logic [POS_W-1:0] pos);
    int unsigned      n, lo, hi, probe;
    logic [POS_W-1:0] lo_pos, hi_pos;
    bit               inside_hit, hit;
    result_t          r;
    n = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_count;
    lo = 0;
    hi = n;
    probe = 0;
    lo_pos = '0;
    hi_pos = '0;
    inside_hit = 1'b0;
    while (lo < hi && !inside_hit) begin
      probe = (lo + hi) >> 1;
      lo_pos = shadow_start[probe];
      hi_pos = shadow_end[probe];
      if (hi_pos <= pos) lo = probe + 1;
      else if (pos < lo_pos) hi = probe;
      else inside_hit = 1'b1;
    end
    hit = (n != 0) && (lo_pos <= pos) && (pos < hi_pos);
    r.found = hit;
    if (hit) r.doc_number = COUNT_W'(probe);
    else if (n == 0 || pos < lo_pos) r.doc_number = '0;
    else r.doc_number = COUNT_W'(probe + 1);
    r.hit_start = hit ? lo_pos : '0;
    r.hit_size  = hit ? hi_pos - lo_pos : '0;
    return r;
  endfunction

  function automatic int written_prefix();
    int i;
    i = 0;
    while (i < TABLE_DEPTH && written[i]) i++;
    return i;
  endfunction

  // Keep one assignment per step on in_valid
  task automatic drive_valid(input bit v);
    if (valid_q != v) begin
      in_valid <= v;
      valid_q = v;
    end
  endtask

  task automatic sender_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if (gaps_on) begin
      if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 30);
      else gap = $urandom_range(1, 4);
      drive_valid(1'b0);
      repeat (gap) @(posedge clk);
    end
    burst_left = $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
  endtask

  task automatic send_item(input logic op, input logic [ADDR_W-1:0] idx,
                           input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                           input logic [POS_W-1:0] t);
    drive_valid(1'b1);
    operation   <= op;
    entry_index <= idx;
    entry_start <= s;
    entry_end   <= e;
    target      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // item taken at this edge
    items_sent++;
    if (op == OP_WRITE) begin
      shadow_start[idx] = s;
      shadow_end[idx]   = e;
      written[idx]      = 1'b1;
    end else begin
      searches_sent++;
      pending_results.push_back(lookup_region(t));
    end
    sender_pause();
  endtask

  task automatic write_entry(input int idx, input logic [POS_W-1:0] s,
                             input logic [POS_W-1:0] e);
    send_item(OP_WRITE, idx[ADDR_W-1:0], s, e, $urandom);
  endtask

  task automatic search_at(input logic [POS_W-1:0] t);
    send_item(OP_SEARCH, ADDR_W'($urandom), $urandom, $urandom, t);
  endtask

  // Write the count only once the block has gone quiet
  task automatic set_region_count(input int v);
    drive_valid(1'b0);
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_count = COUNT_W'(v);
    settings_used++;
  endtask

  // Boundaries and interiors of a randomly picked region among the first cnt, or 0, all ones or a random value
  function automatic logic [POS_W-1:0] pick_target(input int cnt);
    int               k;
    logic [POS_W-1:0] s, e;
    if (cnt == 0) return $urandom;
    k = $urandom_range(0, cnt - 1);
    s = shadow_start[k];
    e = shadow_end[k];
    case ($urandom_range(0, 7))
      0:       return s;
      1:       return e - 1;
      2:       return e;
      3:       return s - 1;
      4:       return s + $urandom_range(0, e - s);
      5:       return '0;
      6:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_sorted_table(input int n, input bit touch_ends);
    longint unsigned span, cur, s, e;
    int              i;
    span = 64'hFFFF_FFFF / (n + 1);
    cur  = touch_ends ? 0 : $urandom_range(0, span);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) != 0 && !(touch_ends && i == 0))
        cur += $urandom_range(0, span / 2);
      s = cur;
      e = s + $urandom_range(1, span / 2);
      if (touch_ends && i == n - 1) e = 64'hFFFF_FFFF;
      write_entry(i, s[POS_W-1:0], e[POS_W-1:0]);
      cur = e;
    end
  endtask

  task automatic test_empty_table();
    set_region_count(0);
    write_entry(TABLE_DEPTH - 1, '1, '0);
    search_at('0);
    search_at('1);
  endtask

  task automatic test_single_region();
    write_entry(0, 32'd100, 32'd200);
    set_region_count(1);
    search_at(32'd99);
    search_at(32'd100);
    search_at(32'd199);
    search_at(32'd200);
    search_at('0);
    search_at('1);
    // region spanning the whole position range
    write_entry(0, '0, '1);
    search_at('0);
    search_at(32'hFFFF_FFFE);
    search_at('1);
  endtask

  task automatic test_small_sorted();
    write_entry(0, 32'd10, 32'd20);
    write_entry(1, 32'd30, 32'd40);
    write_entry(2, 32'd40, 32'd50);
    set_region_count(3);
    search_at(32'd5);
    search_at(32'd25);
    search_at(32'd40);
    search_at(32'd45);
    search_at(32'd50);
    search_at(32'd60);
  endtask

  task automatic test_sorted_tables();
    int n, cnt;
    repeat (8) begin
      n = $urandom_range(1, 24);
      load_sorted_table(n, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0:       cnt = $urandom_range(0, n);
        default: cnt = n;
      endcase
      set_region_count(cnt);
      repeat (20) begin
        if ($urandom_range(0, 9) == 0)
          write_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
        else
          search_at(pick_target(cnt));
      end
    end
  endtask

  task automatic test_unsorted_tables();
    int               n, i;
    logic [POS_W-1:0] s, e;
    repeat (3) begin
      n = $urandom_range(2, 16);
      for (i = 0; i < n; i++) begin
        s = $urandom;
        case ($urandom_range(0, 2))
          0:       e = s + $urandom_range(0, 1000);
          1:       e = s;
          default: e = $urandom;
        endcase
        write_entry(i, s, e);
      end
      set_region_count(n);
      repeat (20) begin
        if ($urandom_range(0, 1) == 0) search_at($urandom);
        else search_at(shadow_start[$urandom_range(0, n - 1)] + $urandom_range(0, 3));
      end
    end
  endtask

  task automatic test_full_table();
    load_sorted_table(TABLE_DEPTH, 1'b1);
    set_region_count(TABLE_DEPTH);
    search_at('0);
    search_at('1);
    repeat (40) search_at(pick_target(written_prefix()));
    // count beyond the table depth clamps to the depth
    set_region_count((1 << COUNT_W) - 1);
    repeat (10) search_at(pick_target(TABLE_DEPTH));
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with no search waiting for it");
          errors++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            errors++;
          end
          if (doc_number !== want.doc_number) begin
            $error("doc_number: expected %0d, got %0d", want.doc_number, doc_number);
            errors++;
          end
          if (hit_start !== want.hit_start) begin
            $error("hit_start: expected %h, got %h", want.hit_start, hit_start);
            errors++;
          end
          if (hit_size !== want.hit_size) begin
            $error("hit_size: expected %h, got %h", want.hit_size, hit_size);
            errors++;
          end
        end
      end
      // stall pattern cycles through free, sparse, periodic and heavy
      case (($time / 2560) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ((($time / 10) % 37) < 12);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : main_sequence
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_single_region();
    test_small_sorted();
    test_sorted_tables();
    test_unsorted_tables();
    test_full_table();
    drive_valid(1'b0);
    waited = 0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("Ran %0d items, %0d of them searches, with %0d results checked.",
             items_sent, searches_sent, results_checked);
    $display("Region count took %0d settings: empty, small, full depth and clamped.",
             settings_used);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
